/* design/pgn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_pkg: shared types, codes and arithmetic for the patch update unit
// Item layout, micro-operation encoding with its program, and the saturating
// Q16.16 helper functions.
// ----------------------------------------------------------------------------
package pgn_pkg;

	localparam int MAX_HALF_WIDTH = 7;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_DEPTH   = 2'd0;
	localparam logic [1:0] CFG_SLOPE_I = 2'd1;
	localparam logic [1:0] CFG_SLOPE_J = 2'd2;
	localparam logic [1:0] CFG_MODE    = 2'd3;

	// result status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_NOUPD = 2'd1;
	localparam logic [1:0] STS_SING  = 2'd2;

	// register file entries and item operand codes
	localparam int NUM_ENTRIES = 23;
	localparam int NUM_ACC     = 9;
	localparam logic [4:0] E_A00 = 5'd0;
	localparam logic [4:0] E_A01 = 5'd1;
	localparam logic [4:0] E_A02 = 5'd2;
	localparam logic [4:0] E_A11 = 5'd3;
	localparam logic [4:0] E_A12 = 5'd4;
	localparam logic [4:0] E_A22 = 5'd5;
	localparam logic [4:0] E_B0  = 5'd6;
	localparam logic [4:0] E_B1  = 5'd7;
	localparam logic [4:0] E_B2  = 5'd8;
	localparam logic [4:0] E_C00 = 5'd9;
	localparam logic [4:0] E_C01 = 5'd10;
	localparam logic [4:0] E_C02 = 5'd11;
	localparam logic [4:0] E_C11 = 5'd12;
	localparam logic [4:0] E_C12 = 5'd13;
	localparam logic [4:0] E_C22 = 5'd14;
	localparam logic [4:0] E_DET = 5'd15;
	localparam logic [4:0] E_X0  = 5'd16;
	localparam logic [4:0] E_X1  = 5'd17;
	localparam logic [4:0] E_X2  = 5'd18;
	localparam logic [4:0] E_AV0 = 5'd19;
	localparam logic [4:0] E_AV1 = 5'd20;
	localparam logic [4:0] E_AV2 = 5'd21;
	localparam logic [4:0] E_R   = 5'd22;
	localparam logic [4:0] E_G   = 5'd23;
	localparam logic [4:0] E_D   = 5'd24;
	localparam logic [4:0] E_N   = 5'd25;

	// micro-operations
	localparam logic [2:0] OP_MAC   = 3'd0;
	localparam logic [2:0] OP_SCALE = 3'd1;
	localparam logic [2:0] OP_DIV   = 3'd2;
	localparam logic [2:0] OP_BRPOS = 3'd3;
	localparam logic [2:0] OP_BRNZ  = 3'd4;
	localparam logic [2:0] OP_ENDI  = 3'd5;
	localparam logic [2:0] OP_FIN   = 3'd6;

	// accumulate source of a multiply-accumulate
	localparam logic [1:0] ACC_ZERO = 2'd0;
	localparam logic [1:0] ACC_DST  = 2'd1;
	localparam logic [1:0] ACC_M    = 2'd2;

	// program entry points
	localparam logic [5:0] P_FULL  = 6'd14;
	localparam logic [5:0] P_FIN   = 6'd42;
	localparam logic [5:0] P_DEPTH = 6'd43;

	typedef struct packed {
		logic [31:0] m;
		logic [31:0] n;
		logic [31:0] d;
		logic [31:0] g;
		logic [3:0]  oi;
		logic [3:0]  oj;
		logic        last;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [2:0] op;
		logic [4:0] dst;
		logic [4:0] xs;
		logic [4:0] ys;
		logic [1:0] acc;
		logic       alt;
	} uop_t;

	function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] ssub64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] v);
		if (!v[63] && (v[62:31] != 32'h0)) return 32'h7FFF_FFFF;
		if (v[63] && (v[62:31] != 32'hFFFF_FFFF)) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] from_mag(input logic neg, input logic over,
			input logic [63:0] m);
		if (!neg) return (over || m[63]) ? S64_MAX : m;
		return (over || m[63]) ? S64_MIN : (~m + 64'd1);
	endfunction

	function automatic uop_t mk(input logic [2:0] op, input logic [4:0] dst,
			input logic [4:0] xs, input logic [4:0] ys, input logic [1:0] acc,
			input logic alt);
		uop_t u;
		u.op  = op;
		u.dst = dst;
		u.xs  = xs;
		u.ys  = ys;
		u.acc = acc;
		u.alt = alt;
		return u;
	endfunction

	// program: per-sample accumulation, full solve, depth-only solve
	function automatic uop_t uop_at(input logic [5:0] pc);
		case (pc)
			6'd0:  return mk(OP_MAC,   E_AV0, E_G,   E_D,   ACC_ZERO, 1'b0);
			6'd1:  return mk(OP_SCALE, E_AV1, E_AV0, E_AV0, ACC_ZERO, 1'b0);
			6'd2:  return mk(OP_SCALE, E_AV2, E_AV0, E_AV0, ACC_ZERO, 1'b1);
			6'd3:  return mk(OP_MAC,   E_R,   E_G,   E_N,   ACC_M,    1'b1);
			6'd4:  return mk(OP_MAC,   E_A00, E_AV0, E_AV0, ACC_DST,  1'b0);
			6'd5:  return mk(OP_MAC,   E_A01, E_AV0, E_AV1, ACC_DST,  1'b0);
			6'd6:  return mk(OP_MAC,   E_A02, E_AV0, E_AV2, ACC_DST,  1'b0);
			6'd7:  return mk(OP_MAC,   E_A11, E_AV1, E_AV1, ACC_DST,  1'b0);
			6'd8:  return mk(OP_MAC,   E_A12, E_AV1, E_AV2, ACC_DST,  1'b0);
			6'd9:  return mk(OP_MAC,   E_A22, E_AV2, E_AV2, ACC_DST,  1'b0);
			6'd10: return mk(OP_MAC,   E_B0,  E_AV0, E_R,   ACC_DST,  1'b0);
			6'd11: return mk(OP_MAC,   E_B1,  E_AV1, E_R,   ACC_DST,  1'b0);
			6'd12: return mk(OP_MAC,   E_B2,  E_AV2, E_R,   ACC_DST,  1'b0);
			6'd13: return mk(OP_ENDI,  E_A00, E_A00, E_A00, ACC_ZERO, 1'b0);
			6'd14: return mk(OP_MAC,   E_C00, E_A11, E_A22, ACC_ZERO, 1'b0);
			6'd15: return mk(OP_MAC,   E_C00, E_A12, E_A12, ACC_DST,  1'b1);
			6'd16: return mk(OP_MAC,   E_C01, E_A02, E_A12, ACC_ZERO, 1'b0);
			6'd17: return mk(OP_MAC,   E_C01, E_A01, E_A22, ACC_DST,  1'b1);
			6'd18: return mk(OP_MAC,   E_C02, E_A01, E_A12, ACC_ZERO, 1'b0);
			6'd19: return mk(OP_MAC,   E_C02, E_A02, E_A11, ACC_DST,  1'b1);
			6'd20: return mk(OP_MAC,   E_C11, E_A00, E_A22, ACC_ZERO, 1'b0);
			6'd21: return mk(OP_MAC,   E_C11, E_A02, E_A02, ACC_DST,  1'b1);
			6'd22: return mk(OP_MAC,   E_C12, E_A01, E_A02, ACC_ZERO, 1'b0);
			6'd23: return mk(OP_MAC,   E_C12, E_A00, E_A12, ACC_DST,  1'b1);
			6'd24: return mk(OP_MAC,   E_C22, E_A00, E_A11, ACC_ZERO, 1'b0);
			6'd25: return mk(OP_MAC,   E_C22, E_A01, E_A01, ACC_DST,  1'b1);
			6'd26: return mk(OP_MAC,   E_DET, E_A00, E_C00, ACC_ZERO, 1'b0);
			6'd27: return mk(OP_MAC,   E_DET, E_A01, E_C01, ACC_DST,  1'b0);
			6'd28: return mk(OP_MAC,   E_DET, E_A02, E_C02, ACC_DST,  1'b0);
			6'd29: return mk(OP_BRNZ,  E_DET, E_DET, E_DET, ACC_ZERO, 1'b0);
			6'd30: return mk(OP_MAC,   E_X0,  E_C00, E_B0,  ACC_ZERO, 1'b0);
			6'd31: return mk(OP_MAC,   E_X0,  E_C01, E_B1,  ACC_DST,  1'b0);
			6'd32: return mk(OP_MAC,   E_X0,  E_C02, E_B2,  ACC_DST,  1'b0);
			6'd33: return mk(OP_MAC,   E_X1,  E_C01, E_B0,  ACC_ZERO, 1'b0);
			6'd34: return mk(OP_MAC,   E_X1,  E_C11, E_B1,  ACC_DST,  1'b0);
			6'd35: return mk(OP_MAC,   E_X1,  E_C12, E_B2,  ACC_DST,  1'b0);
			6'd36: return mk(OP_MAC,   E_X2,  E_C02, E_B0,  ACC_ZERO, 1'b0);
			6'd37: return mk(OP_MAC,   E_X2,  E_C12, E_B1,  ACC_DST,  1'b0);
			6'd38: return mk(OP_MAC,   E_X2,  E_C22, E_B2,  ACC_DST,  1'b0);
			6'd39: return mk(OP_DIV,   E_X0,  E_X0,  E_DET, ACC_ZERO, 1'b0);
			6'd40: return mk(OP_DIV,   E_X1,  E_X1,  E_DET, ACC_ZERO, 1'b0);
			6'd41: return mk(OP_DIV,   E_X2,  E_X2,  E_DET, ACC_ZERO, 1'b0);
			6'd43: return mk(OP_BRPOS, E_A00, E_A00, E_A00, ACC_ZERO, 1'b0);
			6'd44: return mk(OP_DIV,   E_X0,  E_B0,  E_A00, ACC_ZERO, 1'b0);
			default: return mk(OP_FIN, E_A00, E_A00, E_A00, ACC_ZERO, 1'b0);
		endcase
	endfunction

endpackage
`default_nettype wire

/* design/pgn_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_front: sample intake
// Accepts channel samples, clamps the pixel offsets and holds them in a
// two-entry queue for the solver sequencer.
// ----------------------------------------------------------------------------
module pgn_front import pgn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] master_color,
	input  wire logic [31:0] neighbor_color,
	input  wire logic [31:0] neighbor_deriv,
	input  wire logic [31:0] channel_gain,
	input  wire logic [3:0]  offset_i,
	input  wire logic [3:0]  offset_j,
	input  wire logic        last_sample,
	output logic             q_valid,
	output item_t            q_item,
	input  wire logic        q_pop
);

	localparam logic signed [3:0] OFF_MAX = 4'(MAX_HALF_WIDTH);
	localparam logic signed [3:0] OFF_MIN = 4'(-MAX_HALF_WIDTH);

	item_t       entry_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       in_item;

	function automatic logic [3:0] clamp_off(input logic [3:0] v);
		if ($signed(v) > OFF_MAX) return OFF_MAX;
		if ($signed(v) < OFF_MIN) return OFF_MIN;
		return v;
	endfunction

	// clamp the offsets and pack the incoming sample
	always_comb begin
		in_item.m    = master_color;
		in_item.n    = neighbor_color;
		in_item.d    = neighbor_deriv;
		in_item.g    = channel_gain;
		in_item.oi   = clamp_off(offset_i);
		in_item.oj   = clamp_off(offset_j);
		in_item.last = last_sample;
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= in_item;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/pgn_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_mul: multi-cycle Q16.16 multiplier
// Signed 64 by 64 product from four 32 by 32 partial products, shifted right
// by 16 with truncation toward zero and saturated to 64 bits.
// ----------------------------------------------------------------------------
module pgn_mul import pgn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      res
);

	logic [63:0]  am_q;
	logic [63:0]  bm_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [63:0]  prod_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  res_q;
	logic [31:0]  pa;
	logic [31:0]  pb;
	logic [63:0]  pp;
	logic [7:0]   shamt;

	// partial product operands by step
	always_comb begin
		case (step_q)
			3'd0:    begin pa = am_q[31:0];  pb = bm_q[31:0];  end
			3'd1:    begin pa = am_q[31:0];  pb = bm_q[63:32]; end
			3'd2:    begin pa = am_q[63:32]; pb = bm_q[31:0];  end
			default: begin pa = am_q[63:32]; pb = bm_q[63:32]; end
		endcase
		pp = {32'h0, pa} * {32'h0, pb};
		case (step_q)
			3'd1:    shamt = 8'd0;
			3'd4:    shamt = 8'd64;
			default: shamt = 8'd32;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a[63] ? (~a + 64'd1) : a;
			bm_q  <= b[63] ? (~b + 64'd1) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4) prod_q <= pp;
			if ((step_q >= 3'd1) && (step_q <= 3'd4))
				acc_q <= acc_q + ({64'h0, prod_q} << shamt);
			if (step_q == 3'd5)
				res_q <= from_mag(neg_q, |acc_q[127:80], acc_q[79:16]);
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

/* design/pgn_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_div: radix-2 Q16.16 divider
// Computes (n * 2^16) / d truncated toward zero, one quotient bit per cycle,
// saturated to 64 bits.
// ----------------------------------------------------------------------------
module pgn_div import pgn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] n,
	input  wire logic [63:0] d,
	output logic             done,
	output logic [63:0]      res
);

	logic [127:0] num_q;
	logic [127:0] quo_q;
	logic [63:0]  rem_q;
	logic [63:0]  dm_q;
	logic         neg_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  trial;
	logic         qbit;
	logic [63:0]  nm;

	assign nm    = n[63] ? (~n + 64'd1) : n;
	assign trial = {rem_q[62:0], num_q[127]};
	assign qbit  = (trial >= dm_q);

	// shift-subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {48'h0, nm, 16'h0};
			quo_q <= '0;
			rem_q <= '0;
			dm_q  <= d[63] ? (~d + 64'd1) : d;
			neg_q <= n[63] ^ d[63];
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			quo_q <= {quo_q[126:0], qbit};
			rem_q <= qbit ? (trial - dm_q) : trial;
		end
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = from_mag(neg_q, |quo_q[127:64], quo_q[63:0]);

endmodule
`default_nettype wire

/* design/pgn_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgn_back: solver sequencer
// Runs the micro-program over a small register file with the shared
// multiplier and divider: accumulates the normal equations per sample and
// solves on the last one.
// ----------------------------------------------------------------------------
module pgn_back import pgn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	input  wire cfg_wr_t     cfg,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      new_depth,
	output logic [31:0]      new_slope_i,
	output logic [31:0]      new_slope_j,
	output logic [1:0]       solve_status
);

	localparam logic [1:0] S_ISSUE = 2'd0;
	localparam logic [1:0] S_OPND  = 2'd1;
	localparam logic [1:0] S_MUL   = 2'd2;
	localparam logic [1:0] S_DIV   = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  pc_q;
	uop_t        u;

	logic [31:0] sd_q;
	logic [31:0] si_q;
	logic [31:0] sj_q;
	logic        mode_q;

	logic [63:0] mem [NUM_ENTRIES];
	logic [63:0] rd_a_q;
	logic [63:0] rd_b_q;
	logic        rf_a_q;
	logic        rf_b_q;
	logic [NUM_ACC-1:0] fresh_q;

	logic        ren;
	logic [4:0]  ra;
	logic [4:0]  ra_idx;
	logic [4:0]  rb_idx;
	logic        we;
	logic [63:0] wd;

	logic [63:0] va;
	logic [63:0] vb;
	logic [63:0] xv;
	logic [63:0] yv;
	logic [63:0] accv;
	logic [63:0] mac_res;
	logic [3:0]  off;
	logic signed [67:0] sc_full;

	logic        mul_start;
	logic        mul_done;
	logic [63:0] mul_res;
	logic        div_start;
	logic        div_done;
	logic [63:0] div_res;
	logic        fin_go;

	logic [31:0] nd_q;
	logic [31:0] ni_q;
	logic [31:0] nj_q;
	logic [1:0]  sts_q;

	logic        out_valid_q;
	logic [31:0] out_d_q;
	logic [31:0] out_i_q;
	logic [31:0] out_j_q;
	logic [1:0]  out_s_q;

	function automatic logic [63:0] sel_opnd(input logic [4:0] code,
			input logic [63:0] rv, input item_t it);
		case (code)
			E_G:     return {{32{it.g[31]}}, it.g};
			E_D:     return {{32{it.d[31]}}, it.d};
			E_N:     return {{32{it.n[31]}}, it.n};
			default: return rv;
		endcase
	endfunction

	assign u = uop_at(pc_q);

	// operand values, accumulators not yet written read as zero
	always_comb begin
		va      = rf_a_q ? 64'h0 : rd_a_q;
		vb      = rf_b_q ? 64'h0 : rd_b_q;
		xv      = sel_opnd(u.xs, va, q_item);
		yv      = sel_opnd(u.ys, vb, q_item);
		off     = u.alt ? q_item.oj : q_item.oi;
		sc_full = $signed(va) * $signed(off);
		case (u.acc)
			ACC_DST: accv = va;
			ACC_M:   accv = {{32{q_item.m[31]}}, q_item.m};
			default: accv = 64'h0;
		endcase
		mac_res = u.alt ? ssub64(accv, mul_res) : sadd64(accv, mul_res);
	end

	// sequencer control
	always_comb begin
		ren       = 1'b0;
		ra        = u.xs;
		we        = 1'b0;
		wd        = mac_res;
		mul_start = 1'b0;
		div_start = 1'b0;
		q_pop     = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			S_ISSUE: ren = (pc_q != 6'd0) || q_valid;
			S_OPND: begin
				case (u.op)
					OP_MAC: begin
						mul_start = 1'b1;
						ren       = 1'b1;
						ra        = u.dst;
					end
					OP_SCALE: begin
						we = 1'b1;
						wd = sc_full[63:0];
					end
					OP_DIV:  div_start = 1'b1;
					OP_ENDI: q_pop = !q_item.last;
					OP_FIN: begin
						fin_go = !out_valid_q || out_ready;
						q_pop  = fin_go;
					end
					default: ;
				endcase
			end
			S_MUL: we = mul_done;
			default: ;
		endcase
		ra_idx = (ra < 5'(NUM_ENTRIES)) ? ra : 5'd0;
		rb_idx = (u.ys < 5'(NUM_ENTRIES)) ? u.ys : 5'd0;
	end

	// register file
	always_ff @(posedge clk) begin
		if (we) mem[u.dst] <= wd;
		if (ren) begin
			rd_a_q <= mem[ra_idx];
			rd_b_q <= mem[rb_idx];
			rf_a_q <= (ra_idx < 5'(NUM_ACC)) && fresh_q[ra_idx[3:0]];
			rf_b_q <= (rb_idx < 5'(NUM_ACC)) && fresh_q[rb_idx[3:0]];
		end
	end

	pgn_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (xv),
		.b      (yv),
		.done   (mul_done),
		.res    (mul_res)
	);

	pgn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (xv),
		.d      (yv),
		.done   (div_done),
		.res    (div_res)
	);

	// result staging, loaded by the end of the patch and by each division
	always_ff @(posedge clk) begin
		if ((state_q == S_OPND) && (u.op == OP_ENDI) && q_item.last) begin
			nd_q <= sd_q;
			ni_q <= si_q;
			nj_q <= sj_q;
		end
		if ((state_q == S_DIV) && div_done) begin
			case (u.dst)
				E_X1:    ni_q <= sat32(sadd64({{32{si_q[31]}}, si_q}, div_res));
				E_X2:    nj_q <= sat32(sadd64({{32{sj_q[31]}}, sj_q}, div_res));
				default: nd_q <= sat32(sadd64({{32{sd_q[31]}}, sd_q}, div_res));
			endcase
		end
		if (fin_go) begin
			out_d_q <= nd_q;
			out_i_q <= ni_q;
			out_j_q <= nj_q;
			out_s_q <= sts_q;
		end
	end

	// state, configuration and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ISSUE;
			pc_q        <= 6'd0;
			fresh_q     <= '1;
			sts_q       <= STS_OK;
			out_valid_q <= 1'b0;
			sd_q        <= '0;
			si_q        <= '0;
			sj_q        <= '0;
			mode_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_DEPTH:   sd_q   <= cfg.data;
					CFG_SLOPE_I: si_q   <= cfg.data;
					CFG_SLOPE_J: sj_q   <= cfg.data;
					CFG_MODE:    mode_q <= cfg.data[0];
					default: ;
				endcase
			end
			// output register: loaded at patch end, freed by the result transfer
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (we && (u.dst < 5'(NUM_ACC))) fresh_q[u.dst[3:0]] <= 1'b0;
			case (state_q)
				S_ISSUE: if (ren) state_q <= S_OPND;
				S_OPND: begin
					case (u.op)
						OP_MAC: state_q <= S_MUL;
						OP_DIV: state_q <= S_DIV;
						OP_SCALE: begin
							pc_q    <= pc_q + 6'd1;
							state_q <= S_ISSUE;
						end
						OP_BRPOS: begin
							state_q <= S_ISSUE;
							if (!va[63] && (va != 64'h0)) pc_q <= pc_q + 6'd1;
							else begin
								sts_q <= STS_NOUPD;
								pc_q  <= P_FIN;
							end
						end
						OP_BRNZ: begin
							state_q <= S_ISSUE;
							if (va != 64'h0) pc_q <= pc_q + 6'd1;
							else begin
								sts_q <= STS_SING;
								pc_q  <= P_FIN;
							end
						end
						OP_ENDI: begin
							state_q <= S_ISSUE;
							if (q_item.last) begin
								sts_q <= STS_OK;
								pc_q  <= mode_q ? P_FULL : P_DEPTH;
							end else
								pc_q <= 6'd0;
						end
						default: begin
							if (fin_go) begin
								fresh_q     <= '1;
								pc_q        <= 6'd0;
								state_q     <= S_ISSUE;
							end
						end
					endcase
				end
				S_MUL: begin
					if (mul_done) begin
						pc_q    <= pc_q + 6'd1;
						state_q <= S_ISSUE;
					end
				end
				default: begin
					if (div_done) begin
						pc_q    <= pc_q + 6'd1;
						state_q <= S_ISSUE;
					end
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign new_depth    = out_d_q;
	assign new_slope_i  = out_i_q;
	assign new_slope_j  = out_j_q;
	assign solve_status = out_s_q;

`ifndef NO_ASSERTIONS
	// only a held sample is retired
	a_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop without a held sample");

	// the sample under work stays at the queue head
	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ISSUE) |-> q_valid) else $error("sample lost while in work");

	// accumulators read as zero after a patch completes
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (fresh_q == '1)) else $error("accumulators not cleared");
`endif

endmodule
`default_nettype wire

/* design/patch_gauss_newton_update_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// patch_gauss_newton_update_unit: Gauss-Newton patch depth and slope update
// Accumulates the 3x3 normal equations from colour-channel samples and solves
// for the depth (and slope) update on the last sample of a patch.
// ----------------------------------------------------------------------------
// Samples enter a two-entry queue and are worked one at a time by a
// micro-programmed sequencer around one shared 64-bit multiplier (four
// 32x32 partial products) and one radix-2 divider (128 iterations). A
// sample costs 11 multiply-accumulates plus three short steps. The last
// sample of a patch adds in depth-only mode one division, in full mode 24
// multiply-accumulates and three divisions. Results wait in an output
// register while the next samples are taken. Configuration writes are
// always ready.
module patch_gauss_newton_update_unit import pgn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] master_color,
	input  wire logic [31:0] neighbor_color,
	input  wire logic [31:0] neighbor_deriv,
	input  wire logic [31:0] channel_gain,
	input  wire logic [3:0]  offset_i,
	input  wire logic [3:0]  offset_j,
	input  wire logic        last_sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      new_depth,
	output logic [31:0]      new_slope_i,
	output logic [31:0]      new_slope_j,
	output logic [1:0]       solve_status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	cfg_wr_t cfg;

	// configuration transfer
	assign cfg_ready = 1'b1;
	always_comb begin
		cfg.valid = cfg_valid && cfg_ready;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	pgn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.master_color   (master_color),
		.neighbor_color (neighbor_color),
		.neighbor_deriv (neighbor_deriv),
		.channel_gain   (channel_gain),
		.offset_i       (offset_i),
		.offset_j       (offset_j),
		.last_sample    (last_sample),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	pgn_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.cfg          (cfg),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_depth    (new_depth),
		.new_slope_i  (new_slope_i),
		.new_slope_j  (new_slope_j),
		.solve_status (solve_status)
	);

endmodule
`default_nettype wire
